FILE: hw/rtl/ssb_pkg.sv
// Shared types, constants and helpers for the sporadic-server budget unit.
// Depends on nothing; the top level refers to it by scoped names.
`default_nettype none

package ssb_pkg;

    // Ring geometry
    localparam int RING_DEPTH = 8;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int CNT_W      = $clog2(RING_DEPTH + 1);

    // Field widths
    localparam int TIME_W    = 48;
    localparam int AMT_W     = 32;
    localparam int CNT_OUT_W = 4;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 3;

    // Register reset values
    localparam logic [AMT_W-1:0] PERIOD_RESET = 32'd10000000;
    localparam logic [AMT_W-1:0] BUDGET_RESET = 32'd100000;

    // Register indexes (byte address bit 2)
    typedef enum logic [0:0] {
        REG_PERIOD = 1'b0,
        REG_BUDGET = 1'b1
    } reg_idx_t;

    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // One pending replenishment
    typedef struct packed {
        logic [TIME_W-1:0] due;
        logic [AMT_W-1:0]  amount;
    } repl_entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REQ_RD,
        ST_REQ_CHK,
        ST_CMP
    } state_t;

    // Per-cycle actions decoded from the sequencer
    typedef struct packed {
        logic retire;
        logic fin_req;
        logic fin_cmp;
    } ctrl_t;

    // Advance a ring pointer with wrap at any depth
    function automatic ptr_t ring_next(input ptr_t p);
        if (p == PTR_W'(RING_DEPTH - 1))
        begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/sporadic_server_budget_unit.sv
// Sporadic-server budget unit: capacity, peak usage and a replenishment ring.
// Depends on ssb_pkg (types, constants, ring_next).
//
// Each input item is a request (op 0) or a completion (op 1) and yields exactly
// one result item. Pending replenishments live in a small synchronous memory
// with one read port; a request walks the ring head one entry per cycle,
// retiring entries from the head while they are due strictly before now. A
// request registers its result after its read and check states, having
// retired at most the ring depth of 8 entries; a completion registers its
// result from its own state. The next item is accepted only once the sequencer
// is back in idle. A result waits in an output register, so
// the next item is accepted while the previous result is still stalled; the
// sequencer only holds a finished item if that register is still full and
// stalled. The ring needs no clearing pass after reset: only written entries
// are ever read. Configuration goes through a 32-bit APB-style port;
// initial_budget is stored and readable, and budget always reloads its reset
// value on reset.
`default_nettype none

module sporadic_server_budget_unit (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // configuration port
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [ssb_pkg::ADDR_W-1:0]           paddr,
    input  wire logic [ssb_pkg::DATA_W-1:0]           pwdata,
    output logic      [ssb_pkg::DATA_W-1:0]           prdata,
    output logic                                      pready,
    // input channel
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic                                 op,
    input  wire logic [ssb_pkg::TIME_W-1:0]           now,
    input  wire logic [ssb_pkg::AMT_W-1:0]            used_amount,
    // output channel
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic                                      granted,
    output logic      [ssb_pkg::AMT_W-1:0]            capacity_left,
    output logic      [ssb_pkg::TIME_W-1:0]           retry_time,
    output logic      [ssb_pkg::CNT_OUT_W-1:0]        pending_count,
    output logic                                      overflow
);

    // Configuration registers
    logic [ssb_pkg::AMT_W-1:0] period_reg;
    logic [ssb_pkg::AMT_W-1:0] init_budget_reg;
    logic                      cfg_wr;
    ssb_pkg::reg_idx_t         cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = ssb_pkg::reg_idx_t'(paddr[2]);

    // Write configuration on the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg      <= ssb_pkg::PERIOD_RESET;
            init_budget_reg <= ssb_pkg::BUDGET_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                ssb_pkg::REG_PERIOD: period_reg      <= pwdata;
                ssb_pkg::REG_BUDGET: init_budget_reg <= pwdata;
                default: ;
            endcase
        end
    end

    // Read back configuration
    always_comb
    begin
        unique case (cfg_idx)
            ssb_pkg::REG_PERIOD: prdata = period_reg;
            ssb_pkg::REG_BUDGET: prdata = init_budget_reg;
            default:             prdata = '0;
        endcase
    end

    // Sequencer and state
    ssb_pkg::state_t           state_reg;
    ssb_pkg::state_t           state_next;
    ssb_pkg::ctrl_t            ctrl;
    ssb_pkg::ptr_t             wptr_reg;
    ssb_pkg::ptr_t             rptr_reg;
    ssb_pkg::cnt_t             count_reg;
    logic [ssb_pkg::AMT_W-1:0] budget_reg;
    logic [ssb_pkg::AMT_W-1:0] peak_reg;
    logic [ssb_pkg::TIME_W-1:0] grant_time_reg;
    logic                      out_valid_reg;

    // Captured input item
    logic [ssb_pkg::TIME_W-1:0] now_reg;
    logic [ssb_pkg::AMT_W-1:0]  used_reg;

    // Ring memory
    ssb_pkg::repl_entry_t ring_mem [ssb_pkg::RING_DEPTH];
    ssb_pkg::repl_entry_t rd_entry_reg;
    ssb_pkg::repl_entry_t wr_entry;
    ssb_pkg::ptr_t        rd_addr;
    logic                 mem_we;

    logic in_accept;
    logic out_free;

    assign in_stall  = (state_reg != ssb_pkg::ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // Capture the item on acceptance
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            now_reg  <= now;
            used_reg <= used_amount;
        end
    end

    // Datapath terms
    logic [ssb_pkg::AMT_W:0]    budget_sum;
    logic [ssb_pkg::AMT_W-1:0]  budget_add;
    logic [ssb_pkg::AMT_W-1:0]  budget_sub;
    logic [ssb_pkg::TIME_W:0]   repl_sum;
    logic [ssb_pkg::TIME_W-1:0] repl_due;
    logic                       ring_full;
    logic                       ring_busy;
    logic                       head_due;
    logic                       grant_ok;

    assign budget_sum = {1'b0, budget_reg} + {1'b0, rd_entry_reg.amount};
    assign budget_add = budget_sum[ssb_pkg::AMT_W] ? '1 : budget_sum[ssb_pkg::AMT_W-1:0];
    assign budget_sub = (budget_reg > used_reg) ? (budget_reg - used_reg) : '0;
    assign repl_sum   = {1'b0, grant_time_reg} + (ssb_pkg::TIME_W + 1)'(period_reg);
    assign repl_due   = repl_sum[ssb_pkg::TIME_W] ? '1 : repl_sum[ssb_pkg::TIME_W-1:0];
    assign ring_full  = (count_reg == ssb_pkg::CNT_W'(ssb_pkg::RING_DEPTH));
    assign ring_busy  = (count_reg != '0);
    assign head_due   = ring_busy && (rd_entry_reg.due < now_reg);
    assign grant_ok   = (budget_reg >= peak_reg);

    // Decode per-cycle actions and the memory read address
    always_comb
    begin
        ctrl    = '0;
        rd_addr = rptr_reg;
        unique case (state_reg) inside
            ssb_pkg::ST_IDLE,
            ssb_pkg::ST_REQ_RD: ;
            ssb_pkg::ST_REQ_CHK:
            begin
                if (head_due)
                begin
                    ctrl.retire = 1'b1;
                    rd_addr     = ssb_pkg::ring_next(rptr_reg);
                end
                else if (out_free)
                begin
                    ctrl.fin_req = 1'b1;
                end
            end
            ssb_pkg::ST_CMP:
            begin
                ctrl.fin_cmp = out_free;
            end
            default: ;
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ssb_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = op ? ssb_pkg::ST_CMP : ssb_pkg::ST_REQ_RD;
                end
            end
            ssb_pkg::ST_REQ_RD:  state_next = ssb_pkg::ST_REQ_CHK;
            ssb_pkg::ST_REQ_CHK:
            begin
                if (ctrl.fin_req)
                begin
                    state_next = ssb_pkg::ST_IDLE;
                end
            end
            ssb_pkg::ST_CMP:
            begin
                if (ctrl.fin_cmp)
                begin
                    state_next = ssb_pkg::ST_IDLE;
                end
            end
            default: state_next = ssb_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ssb_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Write the ring only on a completion; requests read only after the sequencer
    // has left the completion state, so the sequencing itself keeps accesses apart
    assign mem_we          = ctrl.fin_cmp && !ring_full;
    assign wr_entry.due    = repl_due;
    assign wr_entry.amount = used_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[wptr_reg] <= wr_entry;
        end
        rd_entry_reg <= ring_mem[rd_addr];
    end

    // Update pointers, count, budget, peak and grant time
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg       <= '0;
            rptr_reg       <= '0;
            count_reg      <= '0;
            budget_reg     <= ssb_pkg::BUDGET_RESET;
            peak_reg       <= '0;
            grant_time_reg <= '0;
        end
        else
        begin
            if (ctrl.retire)
            begin
                rptr_reg   <= ssb_pkg::ring_next(rptr_reg);
                count_reg  <= count_reg - ssb_pkg::CNT_W'(1);
                budget_reg <= budget_add;
            end
            if (ctrl.fin_req && grant_ok)
            begin
                grant_time_reg <= now_reg;
            end
            if (ctrl.fin_cmp)
            begin
                if (!ring_full)
                begin
                    wptr_reg  <= ssb_pkg::ring_next(wptr_reg);
                    count_reg <= count_reg + ssb_pkg::CNT_W'(1);
                end
                budget_reg <= budget_sub;
                if (used_reg >= peak_reg)
                begin
                    peak_reg <= used_reg;
                end
            end
        end
    end

    // Hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.fin_req || ctrl.fin_cmp)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Load the result fields
    always_ff @(posedge clk)
    begin
        if (ctrl.fin_req)
        begin
            granted       <= grant_ok;
            capacity_left <= budget_reg;
            retry_time    <= (!grant_ok && ring_busy) ? rd_entry_reg.due : '0;
            pending_count <= ssb_pkg::CNT_OUT_W'(count_reg);
            overflow      <= 1'b0;
        end
        else if (ctrl.fin_cmp)
        begin
            granted       <= 1'b0;
            capacity_left <= budget_sub;
            retry_time    <= '0;
            pending_count <= ring_full ? ssb_pkg::CNT_OUT_W'(count_reg)
                                       : ssb_pkg::CNT_OUT_W'(count_reg + ssb_pkg::CNT_W'(1));
            overflow      <= ring_full;
        end
    end

    assign out_valid = out_valid_reg;

    // Ring occupancy stays within depth
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ssb_pkg::CNT_W'(ssb_pkg::RING_DEPTH))
        else $error("ring count beyond depth");

    // Pointers meet only when the ring is empty or full
    a_ptr_meet: assert property (@(posedge clk) disable iff (!rst_n)
        (wptr_reg == rptr_reg) |->
            (count_reg == '0 || count_reg == ssb_pkg::CNT_W'(ssb_pkg::RING_DEPTH)))
        else $error("ring pointers inconsistent with count");

    // Retiring an entry never lowers the budget
    a_retire_budget: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.retire |=> (budget_reg >= $past(budget_reg)))
        else $error("retirement lowered the budget");

    // A granted result carries no retry time and no overflow
    a_grant_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && granted) |-> (retry_time == '0 && !overflow))
        else $error("granted result with retry time or overflow");

endmodule

`default_nettype wire

FILE: test/tb_sporadic_server_budget_unit.sv
// Self-checking bench for the sporadic-server budget unit: replenishment ring,
// budget saturation, peak-usage admission and ring overflow, with random idling.
// Depends on ssb_pkg and sporadic_server_budget_unit.
`default_nettype none

module tb_sporadic_server_budget_unit;

    localparam int TW          = ssb_pkg::TIME_W;
    localparam int AW          = ssb_pkg::AMT_W;
    localparam int DEPTH       = ssb_pkg::RING_DEPTH;
    localparam int CLK_HALF    = 6;
    localparam int TIMEOUT_CYC = 600000;
    localparam int N_PHASES    = 7;
    localparam int RAND_ITEMS  = 1950;
    localparam int DRAIN_CYC   = 20;

    localparam logic OP_REQUEST  = 1'b0;
    localparam logic OP_COMPLETE = 1'b1;

    localparam logic [TW-1:0] TIME_MAX = '1;
    localparam logic [AW-1:0] AMT_MAX  = '1;

    typedef struct packed {
        logic          op;
        logic [TW-1:0] at;
        logic [AW-1:0] used;
    } sched_event_t;

    typedef struct packed {
        logic                          granted;
        logic [AW-1:0]                 capacity;
        logic [TW-1:0]                 retry;
        logic [ssb_pkg::CNT_OUT_W-1:0] pending;
        logic                          ovf;
    } budget_result_t;

    // DUT connections, all inputs known from time zero
    logic                          clk         = 1'b0;
    logic                          rst_n       = 1'b0;
    logic                          psel        = 1'b0;
    logic                          penable     = 1'b0;
    logic                          pwrite      = 1'b0;
    logic [ssb_pkg::ADDR_W-1:0]    paddr       = '0;
    logic [ssb_pkg::DATA_W-1:0]    pwdata      = '0;
    logic [ssb_pkg::DATA_W-1:0]    prdata;
    logic                          pready;
    logic                          in_valid    = 1'b0;
    logic                          in_stall;
    logic                          op          = 1'b0;
    logic [TW-1:0]                 now         = '0;
    logic [AW-1:0]                 used_amount = '0;
    logic                          out_valid;
    logic                          out_stall   = 1'b0;
    logic                          granted;
    logic [AW-1:0]                 capacity_left;
    logic [TW-1:0]                 retry_time;
    logic [ssb_pkg::CNT_OUT_W-1:0] pending_count;
    logic                          overflow;

    // Predicted block state and configuration
    logic [TW-1:0] ring_due [DEPTH];
    logic [AW-1:0] ring_amt [DEPTH];
    int unsigned   ring_head;
    int unsigned   ring_tail;
    int unsigned   ring_fill;
    logic [AW-1:0] cap_level;
    logic [AW-1:0] peak_mark;
    logic [TW-1:0] last_grant;
    logic [AW-1:0] period_reg;
    logic [AW-1:0] init_budget_reg;   // feeds the budget only at reset, which happens once

    sched_event_t   sched_events[$];
    budget_result_t budget_results_due[$];

    int            mismatch_count = 0;
    int            src_wait       = 0;
    int            sink_wait      = 0;
    bit            src_burst      = 1'b0;
    bit            sink_burst     = 1'b0;
    bit            drv_hold;
    sched_event_t  drv_next;
    logic [TW-1:0] clock_tick     = 48'd30000000;

    sporadic_server_budget_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (op),
        .now           (now),
        .used_amount   (used_amount),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .granted       (granted),
        .capacity_left (capacity_left),
        .retry_time    (retry_time),
        .pending_count (pending_count),
        .overflow      (overflow)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Load the post-reset state
    function void reset_budget_model();
        ring_head       = 0;
        ring_tail       = 0;
        ring_fill       = 0;
        period_reg      = ssb_pkg::PERIOD_RESET;
        init_budget_reg = ssb_pkg::BUDGET_RESET;
        cap_level       = init_budget_reg;
        peak_mark       = '0;
        last_grant      = '0;
    endfunction

    // Advance the state by one item and queue the result it causes
    function void predict_budget_result(input logic op_i, input logic [TW-1:0] at_i,
                                        input logic [AW-1:0] used_i);
        budget_result_t res;
        logic [63:0]    total;
        logic [TW:0]    due_sum;
        res = '0;
        if (op_i == OP_REQUEST)
        begin
            // Retire due entries in ring order, stop at the first one not due
            total = {32'b0, cap_level};
            while (ring_fill > 0 && ring_due[ring_head] < at_i)
            begin
                total     = total + {32'b0, ring_amt[ring_head]};
                ring_head = (ring_head + 1) % DEPTH;
                ring_fill = ring_fill - 1;
            end
            cap_level = (total > {32'b0, AMT_MAX}) ? AMT_MAX : total[AW-1:0];
            if (cap_level >= peak_mark)
            begin
                res.granted = 1'b1;
                last_grant  = at_i;
            end
            else if (ring_fill > 0)
            begin
                res.retry = ring_due[ring_head];
            end
        end
        else
        begin
            // Queue the replenishment unless the ring is full
            if (ring_fill >= DEPTH)
            begin
                res.ovf = 1'b1;
            end
            else
            begin
                due_sum = {1'b0, last_grant} + {{(TW + 1 - AW){1'b0}}, period_reg};
                ring_due[ring_tail] = due_sum[TW] ? TIME_MAX : due_sum[TW-1:0];
                ring_amt[ring_tail] = used_i;
                ring_tail = (ring_tail + 1) % DEPTH;
                ring_fill = ring_fill + 1;
            end
            cap_level = (cap_level > used_i) ? cap_level - used_i : '0;
            if (used_i >= peak_mark)
            begin
                peak_mark = used_i;
            end
        end
        res.capacity = cap_level;
        res.pending  = ring_fill[ssb_pkg::CNT_OUT_W-1:0];
        budget_results_due.push_back(res);
    endfunction

    function void check_field(input string field, input logic [63:0] exp_v,
                              input logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s mismatch: expected %0d, got %0d", field, exp_v, act_v);
            mismatch_count++;
        end
    endfunction

    // Mostly small usage, sometimes large enough to move the peak mark
    function logic [AW-1:0] pick_used();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 80)
        begin
            return AW'($urandom_range(0, 3000));
        end
        else if (roll < 95)
        begin
            return AW'($urandom_range(0, 100000));
        end
        return AW'($urandom_range(0, 200000));
    endfunction

    task automatic queue_event(input logic op_i, input logic [TW-1:0] at_i,
                               input logic [AW-1:0] used_i);
        sched_event_t ev;
        ev.op   = op_i;
        ev.at   = at_i;
        ev.used = used_i;
        sched_events.push_back(ev);
    endtask

    // Request/completion pairs on a forward-moving clock, plus noise
    task automatic queue_random_phase(input int n_items);
        int            queued;
        int            roll;
        logic [AW-1:0] span;
        logic [63:0]   r64;
        queued     = 0;
        span       = period_reg / 4 + 3;
        // jump well past every pending due time
        clock_tick = clock_tick + 48'h2_0000_0000;
        while (queued < n_items)
        begin
            roll = $urandom_range(0, 99);
            r64  = {$urandom, $urandom};
            if (roll < 80)
            begin
                clock_tick = clock_tick + TW'($urandom_range(0, span));
                queue_event(OP_REQUEST, clock_tick, $urandom);
                queued++;
                if ($urandom_range(0, 99) < 75)
                begin
                    queue_event(OP_COMPLETE, r64[TW-1:0], pick_used());
                    queued++;
                end
            end
            else if (roll < 90)
            begin
                // completion with no request before it
                queue_event(OP_COMPLETE, r64[TW-1:0], pick_used());
                queued++;
            end
            else
            begin
                // request back in time
                r64 = r64 % ({16'b0, clock_tick} + 64'd1);
                queue_event(OP_REQUEST, r64[TW-1:0], $urandom);
                queued++;
            end
        end
    endtask

    task automatic write_reg(input ssb_pkg::reg_idx_t idx, input logic [AW-1:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        // Read the register back
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        check_field("prdata", 64'(val), 64'(prdata));
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == ssb_pkg::REG_PERIOD)
        begin
            period_reg = val;
        end
        else
        begin
            init_budget_reg = val;
        end
    endtask

    // Hold until every item is sent and every result is back
    task automatic wait_idle();
        @(negedge clk);
        while (sched_events.size() != 0 || in_valid || budget_results_due.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Driver: present items from the queue with a random gap after each
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            src_wait = 0;
        end
        else
        begin
            drv_hold = in_valid && in_stall;
            if (in_valid && !in_stall)
            begin
                predict_budget_result(op, now, used_amount);
            end
            if (!drv_hold)
            begin
                if (src_wait > 0)
                begin
                    src_wait = src_wait - 1;
                    in_valid <= 1'b0;
                end
                else if (sched_events.size() > 0)
                begin
                    drv_next = sched_events.pop_front();
                    in_valid    <= 1'b1;
                    op          <= drv_next.op;
                    now         <= drv_next.at;
                    used_amount <= drv_next.used;
                    src_wait = src_burst ? 0 : $urandom_range(0, 19);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted result, then stall for a random stretch
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            sink_wait = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (budget_results_due.size() == 0)
                begin
                    $error("result item with no expectation waiting");
                    mismatch_count++;
                end
                else
                begin
                    check_field("granted", 64'(budget_results_due[0].granted),
                                64'(granted));
                    check_field("capacity_left", 64'(budget_results_due[0].capacity),
                                64'(capacity_left));
                    check_field("retry_time", 64'(budget_results_due[0].retry),
                                64'(retry_time));
                    check_field("pending_count", 64'(budget_results_due[0].pending),
                                64'(pending_count));
                    check_field("overflow", 64'(budget_results_due[0].ovf),
                                64'(overflow));
                    void'(budget_results_due.pop_front());
                end
                sink_wait = sink_burst ? 0 : $urandom_range(0, 19);
            end
            if (sink_wait > 0)
            begin
                out_stall <= 1'b1;
                sink_wait = sink_wait - 1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        #(2 * CLK_HALF * TIMEOUT_CYC);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        int            ph;
        int            k;
        logic [AW-1:0] p_val;
        logic [AW-1:0] b_val;
        logic [TW-1:0] far_tick;

        reset_budget_model();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        write_reg(ssb_pkg::REG_PERIOD, ssb_pkg::PERIOD_RESET);
        write_reg(ssb_pkg::REG_BUDGET, $urandom);
        @(negedge clk);

        // Completion before any grant uses grant time zero; ignored fields all ones
        queue_event(OP_COMPLETE, TIME_MAX, 0);
        queue_event(OP_REQUEST, TW'(0), AMT_MAX);
        queue_event(OP_COMPLETE, TW'(0), 60000);
        // Denial while entries are pending
        queue_event(OP_REQUEST, TW'(10), 0);
        queue_event(OP_REQUEST, TW'(10000001), 0);
        // Build ring entries whose due times are out of order
        queue_event(OP_REQUEST, TW'(20), 0);
        queue_event(OP_COMPLETE, TW'(0), 1000);
        queue_event(OP_REQUEST, TW'(10000010), 0);
        queue_event(OP_COMPLETE, TW'(0), 1000);
        queue_event(OP_REQUEST, TW'(5000), 0);
        queue_event(OP_COMPLETE, TW'(0), 1000);
        queue_event(OP_REQUEST, TW'(15000000), 0);
        // Fill the ring, then overflow it
        for (k = 0; k < 6; k++)
        begin
            queue_event(OP_COMPLETE, TW'(0), 1000);
        end
        queue_event(OP_COMPLETE, TW'(0), 50000);
        // Denial with an empty ring, then recover through the budget floor
        queue_event(OP_REQUEST, TW'(25000001), 0);
        queue_event(OP_COMPLETE, TW'(0), 60000);
        queue_event(OP_REQUEST, TW'(25000002), 0);
        wait_idle();

        // Random phases, each under its own period and with new idling
        for (ph = 0; ph < N_PHASES; ph++)
        begin
            case (ph)
                0: p_val = ssb_pkg::PERIOD_RESET;
                1: p_val = 1;
                2: p_val = 16;
                3: p_val = 1000;
                4: p_val = $urandom_range(2, 100000);
                5: p_val = AMT_MAX;
                default: p_val = $urandom | 32'd1;
            endcase
            case (ph % 3)
                0: b_val = '0;
                1: b_val = AMT_MAX;
                default: b_val = $urandom;
            endcase
            write_reg(ssb_pkg::REG_PERIOD, p_val);
            write_reg(ssb_pkg::REG_BUDGET, b_val);
            @(negedge clk);
            src_burst  = ($urandom_range(0, 3) == 0);
            sink_burst = ($urandom_range(0, 3) == 0);
            queue_random_phase(RAND_ITEMS / N_PHASES);
            wait_idle();
        end

        // Top of the time range: saturate budget and due time last, since an
        // entry due at the largest time never retires again
        src_burst  = 1'b0;
        sink_burst = 1'b0;
        write_reg(ssb_pkg::REG_PERIOD, 1);
        @(negedge clk);
        far_tick = 48'h8000_0000_0000;
        queue_event(OP_REQUEST, far_tick, 0);
        queue_event(OP_COMPLETE, TW'(0), AMT_MAX);
        queue_event(OP_COMPLETE, TW'(0), AMT_MAX);
        queue_event(OP_REQUEST, far_tick + TW'(2), 0);
        queue_event(OP_REQUEST, TIME_MAX, 0);
        wait_idle();

        write_reg(ssb_pkg::REG_PERIOD, AMT_MAX);
        @(negedge clk);
        queue_event(OP_COMPLETE, TW'(0), 5);
        queue_event(OP_REQUEST, TIME_MAX, 0);
        wait_idle();

        repeat (DRAIN_CYC) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire
